// File: sv/sti_pkg.sv
// shared constants and types for the sorted table
`timescale 1ns / 1ps

package sti_pkg;

   // table geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // item field widths
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   // request codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } sti_op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD_INDEX = 2'd3
   } sti_status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
   } sti_ctrl_type;

endpackage

// File: sv/sti_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface sti_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            req_type;
   logic signed [sti_pkg::VALUE_W-1:0]    value;
   logic [sti_pkg::INDEX_W-1:0]           index;

   modport source (output valid, output req_type, output value, output index, input ready);
   modport sink   (input valid, input req_type, input value, input index, output ready);
endinterface

interface sti_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            status;
   logic signed [sti_pkg::VALUE_W-1:0]    read_value;
   logic [sti_pkg::COUNT_W-1:0]           count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// File: sv/sti_cell.sv
// one slot of the sorted row: compare against the item value and shift
`timescale 1ns / 1ps

module sti_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  sti_pkg::sti_ctrl_type              ctrl,
   input  logic signed [sti_pkg::VALUE_W-1:0] value,
   // neighbor toward the smaller end
   input  logic signed [sti_pkg::VALUE_W-1:0] left_entry,
   input  logic                               left_valid,
   input  logic                               left_ins_pos,
   // neighbor toward the larger end
   input  logic signed [sti_pkg::VALUE_W-1:0] right_entry,
   input  logic                               right_valid,
   output logic signed [sti_pkg::VALUE_W-1:0] entry,
   output logic                               valid,
   output logic                               ins_pos,
   output logic                               match
);

   logic signed [sti_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                               valid_ff, valid_in;
   logic                               del_pos;

   // position flags are monotone along the row since the row stays sorted
   assign ins_pos = !valid_ff || (entry_ff > value);
   assign del_pos = !valid_ff || (entry_ff >= value);
   assign match   = valid_ff && (entry_ff == value);

   // next slot contents
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.ins && ins_pos) begin
         if (left_ins_pos) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else begin
            entry_in = value;
            valid_in = 1'b1;
         end
      end else if (ctrl.del && del_pos) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   // entry payload, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// File: sv/sorted_table_insert_delete.sv
// sorted table top level: row of compare-and-shift cells plus response register
//
//   channel  dir  fields                          accepted when
//   req      in   req_type, value, index          req.valid && req.ready
//   rsp      out  status, read_value, count       rsp.valid && rsp.ready
//
// for each item all cells compare against the item value in
// parallel and shift by one place in the same clock edge
// one item per cycle unless rsp stalls; the response register is the only stage
// reset clears the cell occupancy flags, the count and the response valid
// a stalled response holds; a new item is taken when the response slot is
// empty or being drained in the same cycle
`timescale 1ns / 1ps

module sorted_table_insert_delete (
   input  logic      clock,
   input  logic      reset,
   sti_req_if.sink   req,
   sti_rsp_if.source rsp
);

   localparam int DEPTH = sti_pkg::DEPTH;
   localparam logic [sti_pkg::CNT_W-1:0] CNT_ONE = 1;

   logic signed [sti_pkg::VALUE_W-1:0] cell_entry   [DEPTH];
   logic                               cell_valid   [DEPTH];
   logic                               cell_ins_pos [DEPTH];
   logic [DEPTH-1:0]                   cell_match;

   sti_pkg::sti_ctrl_type              ctrl;
   logic                               accept;
   logic                               full;
   logic                               found;
   logic [sti_pkg::IDX_W-1:0]          rd_idx;
   logic                               rd_in_range;

   logic [sti_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   sti_pkg::sti_status_type            status_ff, status_in;
   logic signed [sti_pkg::VALUE_W-1:0] read_value_ff, read_value_in;
   logic [31:0]                        count_wide;

   // handshake
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign full  = (32'(count_ff) == DEPTH);
   assign found = |cell_match;

   // command to the row
   always_comb begin
      ctrl.ins = accept && (req.req_type == sti_pkg::OP_INSERT) && !full;
      ctrl.del = accept && (req.req_type == sti_pkg::OP_DELETE) && found;
   end

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [sti_pkg::VALUE_W-1:0] l_entry, r_entry;
      logic                               l_valid, l_pos, r_valid;

      if (i == 0) begin : g_first
         assign l_entry = '0;
         assign l_valid = 1'b0;
         assign l_pos   = 1'b0;
      end else begin : g_mid_l
         assign l_entry = cell_entry[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_pos   = cell_ins_pos[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_entry = '0;
         assign r_valid = 1'b0;
      end else begin : g_mid_r
         assign r_entry = cell_entry[i+1];
         assign r_valid = cell_valid[i+1];
      end

      sti_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .value        (req.value),
         .left_entry   (l_entry),
         .left_valid   (l_valid),
         .left_ins_pos (l_pos),
         .right_entry  (r_entry),
         .right_valid  (r_valid),
         .entry        (cell_entry[i]),
         .valid        (cell_valid[i]),
         .ins_pos      (cell_ins_pos[i]),
         .match        (cell_match[i])
      );
   end

   // read port index
   assign rd_idx      = sti_pkg::IDX_W'(req.index);
   assign rd_in_range = (32'(req.index) < DEPTH) && cell_valid[rd_idx];

   // decode request into response and new count
   always_comb begin
      count_in      = count_ff;
      status_in     = sti_pkg::ST_OK;
      read_value_in = '0;
      unique case (req.req_type)
         sti_pkg::OP_INSERT: begin
            if (full) begin
               status_in = sti_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_ONE;
            end
         end
         sti_pkg::OP_DELETE: begin
            if (found) begin
               count_in = count_ff - CNT_ONE;
            end else begin
               status_in = sti_pkg::ST_NOT_FOUND;
            end
         end
         sti_pkg::OP_READ: begin
            if (rd_in_range) begin
               read_value_in = cell_entry[rd_idx];
            end else begin
               status_in = sti_pkg::ST_BAD_INDEX;
            end
         end
         default: begin
            status_in = sti_pkg::ST_OK;
         end
      endcase
   end

   // response slot valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         read_value_ff <= read_value_in;
      end
   end

   assign count_wide     = 32'(count_ff);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.read_value = read_value_ff;
   assign rsp.count      = count_wide[sti_pkg::COUNT_W-1:0];

endmodule
